// ----- hw/rtl/lkvc_pkg.sv -----
// Shared types and constants for the LRU key/value cache.
package lkvc_pkg;

  localparam int DefEntries   = 16;
  localparam int DefKeyBits   = 64;
  localparam int DefValueBits = 64;
  localparam int CfgBits      = 5;

  localparam logic [CfgBits-1:0] LimitReset = 5'd16;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PROMOTE,
    OP_PUSH,
    OP_REMOVE
  } op_t;

  typedef struct packed {
    logic load_front;
    logic shift_down;
    logic shift_up;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/lkvc_cell.sv -----
// One slot of the recency chain: holds an entry, compares its key, shifts to neighbors.
module lkvc_cell #(
  parameter int KEY_BITS   = lkvc_pkg::DefKeyBits,
  parameter int VALUE_BITS = lkvc_pkg::DefValueBits
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lkvc_pkg::cell_ctrl_t  ctrl,
  input  logic [KEY_BITS-1:0]   cmp_key,
  input  logic [KEY_BITS-1:0]   front_key,
  input  logic [VALUE_BITS-1:0] front_value,
  input  logic                  prev_valid,
  input  logic [KEY_BITS-1:0]   prev_key,
  input  logic [VALUE_BITS-1:0] prev_value,
  input  logic                  next_valid,
  input  logic [KEY_BITS-1:0]   next_key,
  input  logic [VALUE_BITS-1:0] next_value,
  output logic                  valid,
  output logic [KEY_BITS-1:0]   key,
  output logic [VALUE_BITS-1:0] value,
  output logic                  match
);

  logic                  valid_r, valid_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    if (ctrl.load_front) begin
      valid_nxt = 1'b1;
      key_nxt   = front_key;
      value_nxt = front_value;
    end else if (ctrl.shift_down) begin
      valid_nxt = prev_valid;
      key_nxt   = prev_key;
      value_nxt = prev_value;
    end else if (ctrl.shift_up) begin
      valid_nxt = next_valid;
      key_nxt   = next_key;
      value_nxt = next_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign valid = valid_r;
  assign key   = key_r;
  assign value = value_r;
  assign match = valid_r && (key_r == cmp_key);

endmodule

// ----- hw/rtl/lru_key_value_cache.sv -----
// Top level of the fully associative LRU key/value cache.
// The cache is a row of ENTRIES cells kept in recency order: cell 0 holds the most
// recent entry and the valid cells always form a contiguous run from cell 0. An item
// (insert, search, delete) is compared against every cell at once, and in the same
// clock the row moves: a hit is pulled to the front while the newer cells slide back
// one place, a new key enters at the front (the last valid cell drops off when the
// limit is reached, and its key is reported), and a delete closes the gap by sliding
// the older cells forward. One item is taken per clock; the result is registered and
// appears in the cycle after acceptance. Input is stalled only while a finished result
// is itself stalled. The critical path is the key compare feeding the hit encoder
// and the front-of-row value select. max_entries is sampled on every item; 0 acts as
// 1 and values above ENTRIES act as ENTRIES. Lowering it below the current fill drops
// nothing at once: each later new-key insert evicts one entry.
module lru_key_value_cache #(
  parameter int ENTRIES    = lkvc_pkg::DefEntries,
  parameter int KEY_BITS   = lkvc_pkg::DefKeyBits,
  parameter int VALUE_BITS = lkvc_pkg::DefValueBits
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [lkvc_pkg::CfgBits-1:0] cfg_wr_data,
  // item input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_cmd,
  input  logic [KEY_BITS-1:0]          in_key,
  input  logic [VALUE_BITS-1:0]        in_value,
  // result output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic [VALUE_BITS-1:0]        out_found_value,
  output logic                         out_evicted,
  output logic [KEY_BITS-1:0]          out_evicted_key
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = (CW > lkvc_pkg::CfgBits) ? CW : lkvc_pkg::CfgBits;

  // config register
  logic [lkvc_pkg::CfgBits-1:0] max_entries_r, max_entries_nxt;
  logic [LW-1:0]                cfg_ext, limit;

  // fill count
  logic [CW-1:0] count_r, count_nxt;

  // result beat register
  logic                  out_valid_r, out_valid_nxt;
  logic                  hit_r, hit_nxt;
  logic [VALUE_BITS-1:0] found_value_r, found_value_nxt;
  logic                  evicted_r, evicted_nxt;
  logic [KEY_BITS-1:0]   evicted_key_r, evicted_key_nxt;

  // cell row
  logic [ENTRIES-1:0]    cell_valid;
  logic [ENTRIES-1:0]    cell_match;
  logic [ENTRIES-1:0]    cell_last;
  logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
  logic [VALUE_BITS-1:0] cell_value [ENTRIES];
  lkvc_pkg::cell_ctrl_t  cell_ctrl  [ENTRIES];

  logic                  in_fire;
  logic                  any_match;
  logic                  full;
  logic [IW-1:0]         hit_idx;
  logic [IW-1:0]         pos;
  logic [VALUE_BITS-1:0] hit_value;
  logic [KEY_BITS-1:0]   last_key;
  logic [VALUE_BITS-1:0] front_value;
  lkvc_pkg::op_t         op;

  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  // effective limit, clamped to 1..ENTRIES
  assign cfg_ext = LW'(max_entries_r);
  always_comb begin
    if (cfg_ext == '0) begin
      limit = LW'(1);
    end else if (cfg_ext > LW'(ENTRIES)) begin
      limit = LW'(ENTRIES);
    end else begin
      limit = cfg_ext;
    end
  end
  assign full = (LW'(count_r) >= limit);

  // match encode and selects; at most one cell matches
  assign any_match = |cell_match;
  always_comb begin
    hit_idx   = '0;
    hit_value = '0;
    last_key  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cell_match[i]) begin
        hit_idx   = hit_idx | IW'(i);
        hit_value = hit_value | cell_value[i];
      end
      if (cell_last[i]) begin
        last_key = last_key | cell_key[i];
      end
    end
  end

  // row operation for this beat
  always_comb begin
    op = lkvc_pkg::OP_HOLD;
    if (in_fire) begin
      case (in_cmd)
        lkvc_pkg::CMD_INSERT: op = any_match ? lkvc_pkg::OP_PROMOTE : lkvc_pkg::OP_PUSH;
        lkvc_pkg::CMD_SEARCH: op = any_match ? lkvc_pkg::OP_PROMOTE : lkvc_pkg::OP_HOLD;
        lkvc_pkg::CMD_DELETE: op = any_match ? lkvc_pkg::OP_REMOVE : lkvc_pkg::OP_HOLD;
        default:              op = lkvc_pkg::OP_HOLD;
      endcase
    end
  end

  // boundary cell: the hit, or the last cell that takes part in a push
  always_comb begin
    case (op)
      lkvc_pkg::OP_PROMOTE,
      lkvc_pkg::OP_REMOVE: pos = hit_idx;
      lkvc_pkg::OP_PUSH:   pos = full ? IW'(count_r - CW'(1)) : IW'(count_r);
      default:             pos = '0;
    endcase
  end

  // a promoted entry keeps its stored value; a new one takes the input value
  assign front_value = (op == lkvc_pkg::OP_PROMOTE) ? hit_value : in_value;

  // fill count: push into a non-full row grows it, a delete hit shrinks it
  always_comb begin
    count_nxt = count_r;
    case (op)
      lkvc_pkg::OP_PUSH:   count_nxt = full ? count_r : count_r + CW'(1);
      lkvc_pkg::OP_REMOVE: count_nxt = count_r - CW'(1);
      default:             count_nxt = count_r;
    endcase
  end

  assign max_entries_nxt = cfg_wr_en ? cfg_wr_data : max_entries_r;

  // result beat
  always_comb begin
    hit_nxt         = any_match && (in_cmd inside {lkvc_pkg::CMD_INSERT, lkvc_pkg::CMD_SEARCH,
                                                   lkvc_pkg::CMD_DELETE});
    found_value_nxt = (any_match && in_cmd == lkvc_pkg::CMD_SEARCH) ? hit_value : '0;
    evicted_nxt     = (!any_match && in_cmd == lkvc_pkg::CMD_INSERT) && full;
    evicted_key_nxt = evicted_nxt ? last_key : '0;
  end

  always_comb begin
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= lkvc_pkg::LimitReset;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      max_entries_r <= max_entries_nxt;
      count_r       <= count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hit_r         <= hit_nxt;
      found_value_r <= found_value_nxt;
      evicted_r     <= evicted_nxt;
      evicted_key_r <= evicted_key_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = hit_r;
  assign out_found_value = found_value_r;
  assign out_evicted     = evicted_r;
  assign out_evicted_key = evicted_key_r;

  // cell row
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic                  p_valid, n_valid;
    logic [KEY_BITS-1:0]   p_key, n_key;
    logic [VALUE_BITS-1:0] p_value, n_value;

    if (i == 0) begin : g_head
      assign p_valid = cell_valid[i];
      assign p_key   = cell_key[i];
      assign p_value = cell_value[i];
    end else begin : g_body
      assign p_valid = cell_valid[i-1];
      assign p_key   = cell_key[i-1];
      assign p_value = cell_value[i-1];
    end

    if (i == ENTRIES - 1) begin : g_tail
      assign n_valid      = 1'b0;
      assign n_key        = cell_key[i];
      assign n_value      = cell_value[i];
      assign cell_last[i] = cell_valid[i];
    end else begin : g_mid
      assign n_valid      = cell_valid[i+1];
      assign n_key        = cell_key[i+1];
      assign n_value      = cell_value[i+1];
      assign cell_last[i] = cell_valid[i] && !cell_valid[i+1];
    end

    always_comb begin
      cell_ctrl[i].load_front = (op == lkvc_pkg::OP_PROMOTE || op == lkvc_pkg::OP_PUSH) &&
                                (i == 0);
      cell_ctrl[i].shift_down = (op == lkvc_pkg::OP_PROMOTE || op == lkvc_pkg::OP_PUSH) &&
                                (i != 0) && (IW'(i) <= pos);
      cell_ctrl[i].shift_up   = (op == lkvc_pkg::OP_REMOVE) && (IW'(i) >= pos);
    end

    lkvc_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (cell_ctrl[i]),
      .cmp_key     (in_key),
      .front_key   (in_key),
      .front_value (front_value),
      .prev_valid  (p_valid),
      .prev_key    (p_key),
      .prev_value  (p_value),
      .next_valid  (n_valid),
      .next_key    (n_key),
      .next_value  (n_value),
      .valid       (cell_valid[i]),
      .key         (cell_key[i]),
      .value       (cell_value[i]),
      .match       (cell_match[i])
    );
  end

  // valid cells stay packed at the front of the row
  a_valid_packed : assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid + ENTRIES'(1)) & cell_valid) == '0)
    else $error("valid cells not contiguous from the head");

  // fill count tracks the valid cells
  a_count_ok : assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CW'($countones(cell_valid)))
    else $error("fill count out of step with valid cells");

  // keys are unique among valid cells
  a_one_match : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cell_match))
    else $error("key present in more than one cell");

  // an eviction only happens on an insert that missed
  a_evict_miss : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(evicted_r && hit_r))
    else $error("eviction reported together with a hit");

endmodule

// ----- tb/lkvc_scoreboard.sv -----
`timescale 1ns / 100ps
// Scoreboard for the LRU key/value cache: predicts each lookup result and checks the output beats.
module lkvc_scoreboard #(
  parameter int ENTRIES    = lkvc_pkg::DefEntries,
  parameter int KEY_BITS   = lkvc_pkg::DefKeyBits,
  parameter int VALUE_BITS = lkvc_pkg::DefValueBits
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [lkvc_pkg::CfgBits-1:0] cfg_wr_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [1:0]                   in_cmd,
  input  logic [KEY_BITS-1:0]          in_key,
  input  logic [VALUE_BITS-1:0]        in_value,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         out_hit,
  input  logic [VALUE_BITS-1:0]        out_found_value,
  input  logic                         out_evicted,
  input  logic [KEY_BITS-1:0]          out_evicted_key,
  output int                           mismatches,
  output int                           pending,
  output int                           items_seen,
  output int                           hits_seen,
  output int                           evictions_seen
);

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] found_value;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_key;
  } lookup_t;

  logic                         slot_valid [ENTRIES];
  logic [KEY_BITS-1:0]          slot_key   [ENTRIES];
  logic [VALUE_BITS-1:0]        slot_value [ENTRIES];
  int                           slot_age   [ENTRIES];
  int                           fill = 0;
  logic [lkvc_pkg::CfgBits-1:0] limit_reg = lkvc_pkg::LimitReset;
  lookup_t                      expected_q [$];
  int                           fail_count = 0;
  int                           n_items = 0;
  int                           n_hits = 0;
  int                           n_evict = 0;

  // 0 behaves as 1, anything past the array size saturates
  function automatic int capacity();
    if (limit_reg == 0) return 1;
    if (int'(limit_reg) > ENTRIES) return ENTRIES;
    return int'(limit_reg);
  endfunction

  function automatic void make_recent(input int s);
    int r;
    r = slot_age[s];
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && slot_age[i] < r) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function automatic void free_slot(input int s);
    int r;
    r = slot_age[s];
    slot_valid[s] = 1'b0;
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && slot_age[i] > r) slot_age[i]--;
    if (fill > 0) fill--;
  endfunction

  function automatic lookup_t predict_lookup(input logic [1:0] cmd,
                                             input logic [KEY_BITS-1:0] key,
                                             input logic [VALUE_BITS-1:0] value);
    lookup_t res;
    int found;
    int target;
    int oldest;
    res = '0;
    found = -1;
    target = -1;
    oldest = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (found < 0 && slot_valid[i] && slot_key[i] == key) found = i;
    case (cmd)
      lkvc_pkg::CMD_INSERT: begin
        if (found >= 0) begin
          // present key: old value stays, entry just moves to the front
          res.hit = 1'b1;
          make_recent(found);
        end else begin
          if (fill >= capacity()) begin
            for (int i = 0; i < ENTRIES; i++)
              if (slot_valid[i] && (oldest < 0 || slot_age[i] > slot_age[oldest])) oldest = i;
            if (oldest >= 0) begin
              res.evicted = 1'b1;
              res.evicted_key = slot_key[oldest];
              free_slot(oldest);
              target = oldest;
            end
          end
          for (int i = 0; i < ENTRIES; i++)
            if (target < 0 && !slot_valid[i]) target = i;
          if (target >= 0) begin
            for (int i = 0; i < ENTRIES; i++)
              if (slot_valid[i]) slot_age[i]++;
            slot_valid[target] = 1'b1;
            slot_key[target] = key;
            slot_value[target] = value;
            slot_age[target] = 0;
            fill++;
          end
        end
      end
      lkvc_pkg::CMD_SEARCH: begin
        if (found >= 0) begin
          res.hit = 1'b1;
          res.found_value = slot_value[found];
          make_recent(found);
        end
      end
      lkvc_pkg::CMD_DELETE: begin
        if (found >= 0) begin
          res.hit = 1'b1;
          free_slot(found);
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic void flag(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch on %s: expected %h, got %h", field, want, got);
  endfunction

  always @(posedge clk) begin
    lookup_t want;
    lookup_t got;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
      fill = 0;
      limit_reg = lkvc_pkg::LimitReset;
      expected_q.delete();
    end else begin
      if (cfg_wr_en) limit_reg = cfg_wr_data;
      // drain before push: a beat can never belong to the item taken on the same edge
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result beat with nothing outstanding");
        end else begin
          want = expected_q.pop_front();
          got = '{out_hit, out_found_value, out_evicted, out_evicted_key};
          if (got.hit !== want.hit) flag("hit", want.hit, got.hit);
          if (got.found_value !== want.found_value)
            flag("found_value", want.found_value, got.found_value);
          if (got.evicted !== want.evicted) flag("evicted", want.evicted, got.evicted);
          if (got.evicted_key !== want.evicted_key)
            flag("evicted_key", want.evicted_key, got.evicted_key);
        end
      end
      if (in_valid && !in_stall) begin
        want = predict_lookup(in_cmd, in_key, in_value);
        expected_q.push_back(want);
        n_items++;
        if (want.hit) n_hits++;
        if (want.evicted) n_evict++;
      end
    end
    mismatches     <= fail_count;
    pending        <= expected_q.size();
    items_seen     <= n_items;
    hits_seen      <= n_hits;
    evictions_seen <= n_evict;
  end

endmodule

// ----- tb/lru_key_value_cache_tb.sv -----
`timescale 1ns / 100ps
// Top of the LRU cache testbench: clock, reset, stimulus, back-pressure and verdict.
module lru_key_value_cache_tb;

  localparam int          KEY_BITS    = lkvc_pkg::DefKeyBits;
  localparam int          VALUE_BITS  = lkvc_pkg::DefValueBits;
  localparam int          POOL_SIZE   = 24;
  // far beyond the worst-case run length for ~550 beats
  localparam int          CYCLE_LIMIT = 400000;
  // the fourth command code does nothing in the cache
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TOP_BIT     = 64'h8000_0000_0000_0000;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_wr_en = 1'b0;
  logic [lkvc_pkg::CfgBits-1:0] cfg_wr_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [1:0]                   in_cmd = lkvc_pkg::CMD_SEARCH;
  logic [KEY_BITS-1:0]          in_key = '0;
  logic [VALUE_BITS-1:0]        in_value = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         out_hit;
  logic [VALUE_BITS-1:0]        out_found_value;
  logic                         out_evicted;
  logic [KEY_BITS-1:0]          out_evicted_key;

  int mismatches;
  int pending;
  int items_seen;
  int hits_seen;
  int evictions_seen;
  int cycles = 0;

  // when set, neither side idles: back-to-back beats on both channels
  bit calm = 1'b0;

  // Keys are mostly drawn from a small pool so that hits, re-inserts, deletes and
  // evictions all happen often; the pool carries the key extremes as well.
  logic [KEY_BITS-1:0] key_pool [POOL_SIZE];

  lru_key_value_cache uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_found_value (out_found_value),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key)
  );

  lkvc_scoreboard scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_found_value (out_found_value),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key),
    .mismatches      (mismatches),
    .pending         (pending),
    .items_seen      (items_seen),
    .hits_seen       (hits_seen),
    .evictions_seen  (evictions_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: before every beat, stall for a random number of cycles (none when calm).
  // out_stall only changes at clock edges and never twice in one step.
  initial begin
    int wait_cycles;
    wait (rst_n);
    @(posedge clk);
    forever begin
      wait_cycles = calm ? 0 : $urandom_range(0, 19);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // One input beat: optional idle gap, then hold the payload until the cache takes it.
  // With no gap the next payload follows on the accepting edge, so valid stays high.
  task automatic send_item(input logic [1:0] cmd, input logic [KEY_BITS-1:0] key,
                           input logic [VALUE_BITS-1:0] value);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_key   <= key;
    in_value <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every outstanding lookup has come back.
  // Each beat yields exactly one result, registered in the cycle after it is taken.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  // Only called with the cache idle.
  task automatic write_limit(input logic [lkvc_pkg::CfgBits-1:0] limit);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= limit;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic under one limit setting. Keys come from the first `span` pool
  // entries, with an occasional fresh key to force misses. Part way through, the
  // sender holds off until the pipeline is empty, then resumes.
  task automatic run_phase(input logic [lkvc_pkg::CfgBits-1:0] limit, input int span,
                           input int count, input bit quiet);
    int pause_at;
    int pick;
    logic [1:0] cmd;
    logic [KEY_BITS-1:0] key;
    write_limit(limit);
    calm = quiet;
    pause_at = $urandom_range(count / 4, 3 * count / 4);
    for (int n = 0; n < count; n++) begin
      if (n == pause_at) settle();
      pick = $urandom_range(0, 99);
      if (pick < 45) cmd = lkvc_pkg::CMD_INSERT;
      else if (pick < 80) cmd = lkvc_pkg::CMD_SEARCH;
      else if (pick < 96) cmd = lkvc_pkg::CMD_DELETE;
      else cmd = CMD_UNUSED;
      if ($urandom_range(0, 6) == 0) key = {$urandom, $urandom};
      else key = key_pool[$urandom_range(0, span - 1)];
      send_item(cmd, key, {$urandom, $urandom});
    end
    settle();
    calm = 1'b0;
  endtask

  initial begin
    int lim;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = ALL_ONES;
    key_pool[2] = TOP_BIT;
    key_pool[3] = 64'd1;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: empty store, key/value extremes, every command ---
    write_limit(5'd16);
    send_item(lkvc_pkg::CMD_SEARCH, '0, ALL_ONES);       // miss on empty store
    send_item(lkvc_pkg::CMD_DELETE, '0, '0);             // delete miss
    send_item(CMD_UNUSED, '0, ALL_ONES);                 // unused code, no effect
    send_item(lkvc_pkg::CMD_INSERT, '0, ALL_ONES);
    send_item(lkvc_pkg::CMD_INSERT, ALL_ONES, '0);
    send_item(lkvc_pkg::CMD_SEARCH, '0, '0);             // hit, moves to front
    send_item(lkvc_pkg::CMD_SEARCH, '0, '0);             // hit on the front entry
    send_item(lkvc_pkg::CMD_INSERT, '0, 64'h1234);       // present key: old value kept
    send_item(lkvc_pkg::CMD_SEARCH, '0, '0);
    send_item(lkvc_pkg::CMD_DELETE, ALL_ONES, '0);       // delete hit
    send_item(lkvc_pkg::CMD_SEARCH, ALL_ONES, '0);       // gone now
    send_item(lkvc_pkg::CMD_INSERT, TOP_BIT, 64'h5555_5555_5555_5555);
    send_item(lkvc_pkg::CMD_INSERT, 64'd1, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(lkvc_pkg::CMD_INSERT, 64'd2, 64'd3);
    settle();

    // limit dropped below the fill: nothing leaves until a new key arrives
    write_limit(5'd2);
    send_item(lkvc_pkg::CMD_INSERT, 64'd3, 64'd30);      // evicts the oldest
    send_item(lkvc_pkg::CMD_SEARCH, TOP_BIT, '0);
    send_item(lkvc_pkg::CMD_INSERT, 64'd4, 64'd40);
    send_item(lkvc_pkg::CMD_DELETE, 64'd2, '0);          // fill only falls by delete
    settle();

    write_limit(5'd0);                                   // acts as a limit of one
    send_item(lkvc_pkg::CMD_INSERT, 64'd5, 64'd50);
    send_item(lkvc_pkg::CMD_INSERT, 64'd6, ALL_ONES);
    settle();

    write_limit(5'd31);                                  // saturates at the array size
    send_item(lkvc_pkg::CMD_INSERT, 64'd7, 64'd70);
    send_item(lkvc_pkg::CMD_SEARCH, 64'd6, '0);
    send_item(lkvc_pkg::CMD_SEARCH, 64'd5, '0);
    settle();

    // --- random phases over the limit range ---
    run_phase(5'd16, 20, 80, 1'b0);
    run_phase(5'd4, 7, 70, 1'b1);
    run_phase(5'd1, 3, 50, 1'b0);
    run_phase(5'd0, 3, 40, 1'b0);
    run_phase(5'd31, 22, 80, 1'b0);
    run_phase(5'd3, 8, 70, 1'b0);                        // lowered below a full store
    lim = $urandom_range(2, 15);
    run_phase(lim[lkvc_pkg::CfgBits-1:0], lim + 3, 70, 1'b0);
    run_phase(5'd17, 18, 60, 1'b1);

    repeat (5) @(posedge clk);
    $display("summary: %0d lookups (%0d hits, %0d evictions), limits 0 to 31, stalls on both sides",
             items_seen, hits_seen, evictions_seen);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_cell.sv
hw/rtl/lru_key_value_cache.sv
tb/lkvc_scoreboard.sv
tb/lru_key_value_cache_tb.sv
